/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, quiet during arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

/* rtl/core/mvs_pkg.sv */
// ----------------------------------------------------------------------------
// mvs_pkg
// widths, register codes, beat types and saturation helpers for the
// multivector vector score pipeline
// ----------------------------------------------------------------------------
package mvs_pkg;

	localparam int FRAC_BITS  = 12;
	localparam int WEDGE_GAIN = 1000;

	localparam int IN_W     = 16;
	localparam int PROD_W   = 2 * IN_W;
	// three products of 2^30 at most: 33 bits signed holds any sum
	localparam int SUM_W    = PROD_W + 1;
	localparam int R_W      = SUM_W - FRAC_BITS;
	// a floored component stays strictly below 2^(R_W-1) in magnitude
	localparam int MAG_W    = R_W - 1;
	localparam int SQ_W     = 2 * MAG_W + 2;
	localparam int ROOT_W   = SQ_W / 2;
	localparam int REM_W    = ROOT_W + 2;

	localparam int CONTR_W     = 20;
	localparam int WEDGE_W     = 21;
	localparam int SCORE_W     = 31;
	localparam int GAIN_W      = 16;
	localparam int GPROD_W     = WEDGE_W + GAIN_W;
	localparam int SCORE_SUM_W = GPROD_W + 1;

	localparam logic [63:0] CONTR_MAX = (64'd1 << CONTR_W) - 64'd1;
	localparam logic [63:0] WEDGE_MAX = (64'd1 << WEDGE_W) - 64'd1;
	localparam logic [63:0] SCORE_MAX = (64'd1 << SCORE_W) - 64'd1;

	localparam logic [GPROD_W-1:0] GAIN_EXT = GPROD_W'(WEDGE_GAIN);

	localparam int CFG_IDX_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STATE_E1     = 4'd0,
		REG_STATE_E2     = 4'd1,
		REG_STATE_E3     = 4'd2,
		REG_STATE_PSEUDO = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [IN_W-1:0] e1;
		logic signed [IN_W-1:0] e2;
		logic signed [IN_W-1:0] e3;
		logic signed [IN_W-1:0] ps;
	} state_mv_t;

	// one beat travelling down the root chain
	typedef struct packed {
		logic [SQ_W-1:0]    rad;
		logic [REM_W-1:0]   rem;
		logic [ROOT_W-1:0]  root;
		logic [CONTR_W-1:0] contr;
	} sqrt_beat_t;

	function automatic logic [CONTR_W-1:0] sat_contr(input logic [63:0] x);
		if (x > CONTR_MAX) begin
			return '1;
		end
		return x[CONTR_W-1:0];
	endfunction

	function automatic logic [WEDGE_W-1:0] sat_wedge(input logic [63:0] x);
		if (x > WEDGE_MAX) begin
			return '1;
		end
		return x[WEDGE_W-1:0];
	endfunction

	function automatic logic [SCORE_W-1:0] sat_score(input logic [63:0] x);
		if (x > SCORE_MAX) begin
			return '1;
		end
		return x[SCORE_W-1:0];
	endfunction

endpackage

/* rtl/core/mvs_front.sv */
// ----------------------------------------------------------------------------
// mvs_front
// five-stage front end: products, grade sums, floor and magnitude,
// squares, squared bivector norm
// ----------------------------------------------------------------------------
module mvs_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [mvs_pkg::IN_W-1:0] vec_x,
	input  logic signed [mvs_pkg::IN_W-1:0] vec_y,
	input  logic signed [mvs_pkg::IN_W-1:0] vec_z,
	input  mvs_pkg::state_mv_t              state,
	output logic                            out_valid,
	input  logic                            out_ready,
	output mvs_pkg::sqrt_beat_t             out_beat
);

	// floor by FRAC_BITS, then magnitude
	function automatic logic [mvs_pkg::MAG_W-1:0] floor_mag(
		input logic signed [mvs_pkg::SUM_W-1:0] s
	);
		logic signed [mvs_pkg::SUM_W-1:0] sh;
		logic        [mvs_pkg::SUM_W-1:0] mg;
		sh = s >>> mvs_pkg::FRAC_BITS;
		mg = sh[mvs_pkg::SUM_W-1] ? mvs_pkg::SUM_W'(-sh) : mvs_pkg::SUM_W'(sh);
		return mg[mvs_pkg::MAG_W-1:0];
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	logic signed [mvs_pkg::PROD_W-1:0] m1v1_s1, m2v2_s1, m3v3_s1;
	logic signed [mvs_pkg::PROD_W-1:0] m1v2_s1, m2v1_s1, mtv3_s1;
	logic signed [mvs_pkg::PROD_W-1:0] m2v3_s1, m3v2_s1, mtv1_s1;
	logic signed [mvs_pkg::PROD_W-1:0] m3v1_s1, m1v3_s1, mtv2_s1;

	logic signed [mvs_pkg::SUM_W-1:0] r0_s2, r12_s2, r23_s2, r31_s2;

	logic [mvs_pkg::CONTR_W-1:0] contr_s3, contr_s4, contr_s5;
	logic [mvs_pkg::MAG_W-1:0]   a_s3, b_s3, c_s3;

	logic [2*mvs_pkg::MAG_W-1:0] sq_a_s4, sq_b_s4, sq_c_s4;
	logic [mvs_pkg::SQ_W-1:0]    sumsq_s5;

	// a stage loads when it is empty or its successor moves on
	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			m1v1_s1 <= state.e1 * vec_x;
			m2v2_s1 <= state.e2 * vec_y;
			m3v3_s1 <= state.e3 * vec_z;
			m1v2_s1 <= state.e1 * vec_y;
			m2v1_s1 <= state.e2 * vec_x;
			mtv3_s1 <= state.ps * vec_z;
			m2v3_s1 <= state.e2 * vec_z;
			m3v2_s1 <= state.e3 * vec_y;
			mtv1_s1 <= state.ps * vec_x;
			m3v1_s1 <= state.e3 * vec_x;
			m1v3_s1 <= state.e1 * vec_z;
			mtv2_s1 <= state.ps * vec_y;
		end
		if (en_s2 && v_s1) begin
			r0_s2  <= mvs_pkg::SUM_W'(m1v1_s1) + mvs_pkg::SUM_W'(m2v2_s1)
				+ mvs_pkg::SUM_W'(m3v3_s1);
			r12_s2 <= mvs_pkg::SUM_W'(m1v2_s1) - mvs_pkg::SUM_W'(m2v1_s1)
				+ mvs_pkg::SUM_W'(mtv3_s1);
			r23_s2 <= mvs_pkg::SUM_W'(m2v3_s1) - mvs_pkg::SUM_W'(m3v2_s1)
				+ mvs_pkg::SUM_W'(mtv1_s1);
			r31_s2 <= mvs_pkg::SUM_W'(m3v1_s1) - mvs_pkg::SUM_W'(m1v3_s1)
				+ mvs_pkg::SUM_W'(mtv2_s1);
		end
		if (en_s3 && v_s2) begin
			contr_s3 <= mvs_pkg::sat_contr(64'(floor_mag(r0_s2)));
			a_s3     <= floor_mag(r12_s2);
			b_s3     <= floor_mag(r23_s2);
			c_s3     <= floor_mag(r31_s2);
		end
		if (en_s4 && v_s3) begin
			contr_s4 <= contr_s3;
			sq_a_s4  <= (2*mvs_pkg::MAG_W)'(a_s3) * (2*mvs_pkg::MAG_W)'(a_s3);
			sq_b_s4  <= (2*mvs_pkg::MAG_W)'(b_s3) * (2*mvs_pkg::MAG_W)'(b_s3);
			sq_c_s4  <= (2*mvs_pkg::MAG_W)'(c_s3) * (2*mvs_pkg::MAG_W)'(c_s3);
		end
		if (en_s5 && v_s4) begin
			contr_s5 <= contr_s4;
			sumsq_s5 <= mvs_pkg::SQ_W'(sq_a_s4) + mvs_pkg::SQ_W'(sq_b_s4)
				+ mvs_pkg::SQ_W'(sq_c_s4);
		end
	end

	assign out_valid      = v_s5;
	assign out_beat.rad   = sumsq_s5;
	assign out_beat.rem   = '0;
	assign out_beat.root  = '0;
	assign out_beat.contr = contr_s5;

endmodule

/* rtl/core/mvs_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// mvs_sqrt_cell
// one cell of the integer square root chain: brings down two radicand bits,
// settles one root bit by trial subtraction
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mvs_sqrt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mvs_pkg::sqrt_beat_t in_beat,
	output logic                out_valid,
	input  logic                out_ready,
	output mvs_pkg::sqrt_beat_t out_beat
);

	logic                       valid_q;
	mvs_pkg::sqrt_beat_t        beat_q;
	mvs_pkg::sqrt_beat_t        beat_d;
	logic [mvs_pkg::REM_W-1:0]  cur;
	logic [mvs_pkg::REM_W-1:0]  trial;
	logic                       ge;

	// remainder never exceeds twice the partial root, so its low bits suffice here
	assign cur   = {in_beat.rem[mvs_pkg::ROOT_W-1:0], in_beat.rad[mvs_pkg::SQ_W-1 -: 2]};
	assign trial = {1'b0, in_beat.root[mvs_pkg::ROOT_W-2:0], 2'b01};
	assign ge    = cur >= trial;

	always_comb begin
		beat_d       = in_beat;
		beat_d.rad   = {in_beat.rad[mvs_pkg::SQ_W-3:0], 2'b00};
		beat_d.rem   = ge ? (cur - trial) : cur;
		beat_d.root  = {in_beat.root[mvs_pkg::ROOT_W-2:0], ge};
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_q <= beat_d;
		end
	end

	assign out_valid = valid_q;
	assign out_beat  = beat_q;

	// partial root is the floor root of the bits seen so far
	`ASSERT_CLK(a_rem_bound, valid_q |-> (beat_q.rem <= {1'b0, beat_q.root, 1'b0}), "sqrt cell remainder above twice root")

endmodule

/* rtl/core/mvs_score.sv */
// ----------------------------------------------------------------------------
// mvs_score
// two-stage back end: saturate, weight the wedge magnitude, add and
// saturate the score into the output register
// ----------------------------------------------------------------------------
module mvs_score (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  mvs_pkg::sqrt_beat_t          in_beat,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mvs_pkg::CONTR_W-1:0]  contraction,
	output logic [mvs_pkg::WEDGE_W-1:0]  wedge_magnitude,
	output logic [mvs_pkg::SCORE_W-1:0]  score
);

	logic v_s1, v_s2;
	logic en_s1, en_s2;

	logic [mvs_pkg::WEDGE_W-1:0] wedge_sat;

	logic [mvs_pkg::CONTR_W-1:0] contr_s1, contr_s2;
	logic [mvs_pkg::WEDGE_W-1:0] wedge_s1, wedge_s2;
	logic [mvs_pkg::GPROD_W-1:0] gprod_s1;
	logic [mvs_pkg::SCORE_W-1:0] score_s2;

	assign wedge_sat = mvs_pkg::sat_wedge(64'(in_beat.root));

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			contr_s1 <= in_beat.contr;
			wedge_s1 <= wedge_sat;
			gprod_s1 <= mvs_pkg::GPROD_W'(wedge_sat) * mvs_pkg::GAIN_EXT;
		end
		if (en_s2 && v_s1) begin
			contr_s2 <= contr_s1;
			wedge_s2 <= wedge_s1;
			score_s2 <= mvs_pkg::sat_score(64'(mvs_pkg::SCORE_SUM_W'(contr_s1)
				+ mvs_pkg::SCORE_SUM_W'(gprod_s1)));
		end
	end

	assign out_valid       = v_s2;
	assign contraction     = contr_s2;
	assign wedge_magnitude = wedge_s2;
	assign score           = score_s2;

endmodule

/* rtl/core/multivector_vector_score.sv */
// ----------------------------------------------------------------------------
// multivector_vector_score
// scores 3-vectors against a fixed Cl(3,0) multivector: |scalar part|,
// floor root of the bivector norm, and their weighted sum
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    vec_x, vec_y, vec_z
// out      source     out_valid / out_ready  contraction, wedge_magnitude, score
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one beat per cycle in and out when out_ready stays high
// the path runs through five front stages, one root cell per result bit,
// then the weighting and output registers
// each stage holds its beat only while the next is full, so bubbles close up
// under an output stall and in_ready falls once every stage is occupied
// reset empties the pipeline and clears the state registers; no clearing pass
// cfg_ready is always high; unknown register indexes are dropped
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multivector_vector_score (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [mvs_pkg::IN_W-1:0]      vec_x,
	input  logic signed [mvs_pkg::IN_W-1:0]      vec_y,
	input  logic signed [mvs_pkg::IN_W-1:0]      vec_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [mvs_pkg::CONTR_W-1:0]          contraction,
	output logic [mvs_pkg::WEDGE_W-1:0]          wedge_magnitude,
	output logic [mvs_pkg::SCORE_W-1:0]          score,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mvs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mvs_pkg::IN_W-1:0]             cfg_data
);

	mvs_pkg::state_mv_t  state_q;

	mvs_pkg::sqrt_beat_t chain_beat  [mvs_pkg::ROOT_W+1];
	logic                chain_valid [mvs_pkg::ROOT_W+1];
	logic                chain_ready [mvs_pkg::ROOT_W+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cfg_valid) begin
			unique case (mvs_pkg::cfg_reg_t'(cfg_index))
				mvs_pkg::REG_STATE_E1:     state_q.e1 <= cfg_data;
				mvs_pkg::REG_STATE_E2:     state_q.e2 <= cfg_data;
				mvs_pkg::REG_STATE_E3:     state_q.e3 <= cfg_data;
				mvs_pkg::REG_STATE_PSEUDO: state_q.ps <= cfg_data;
				default: ;
			endcase
		end
	end

	mvs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.vec_x     (vec_x),
		.vec_y     (vec_y),
		.vec_z     (vec_z),
		.state     (state_q),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_beat  (chain_beat[0])
	);

	for (genvar i = 0; i < mvs_pkg::ROOT_W; i++) begin : g_cell
		mvs_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_beat   (chain_beat[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_beat  (chain_beat[i+1])
		);
	end

	mvs_score u_score (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (chain_valid[mvs_pkg::ROOT_W]),
		.in_ready        (chain_ready[mvs_pkg::ROOT_W]),
		.in_beat         (chain_beat[mvs_pkg::ROOT_W]),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.contraction     (contraction),
		.wedge_magnitude (wedge_magnitude),
		.score           (score)
	);

	// score is a sum of non-negative terms, so it never falls below either
	`ASSERT_NEVER(a_score_ge_contr, out_valid && (score < mvs_pkg::SCORE_W'(contraction)), "score below contraction")
	`ASSERT_CLK(a_score_ge_gain, (out_valid && (wedge_magnitude != '0)) |-> (score >= mvs_pkg::SCORE_W'(mvs_pkg::WEDGE_GAIN)), "score below wedge gain")

endmodule
